### src/sdpcm_pkg.sv
// Package for the SDP connection/media extractor: payload types, state codes,
// keyword tables and result queue sizing. No dependencies.
`timescale 1ns / 1ps

package sdpcm_pkg;

    // request payloads
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } text_item_t;

    typedef struct packed {
        logic        report_kind;
        logic [7:0]  address_char;
        logic [3:0]  status;
        logic [15:0] media_port;
        logic        last_of_run;
    } report_item_t;

    localparam int MAX_TOKEN_LENGTH_DEF = 100;

    // scan modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TOKEN = 2'd1;
    localparam logic [1:0] MODE_SKIP  = 2'd2;

    // connection tracker steps
    localparam logic [3:0] CS_SEEK     = 4'd0;
    localparam logic [3:0] CS_IN       = 4'd1;
    localparam logic [3:0] CS_IP4      = 4'd2;
    localparam logic [3:0] CS_ADDR     = 4'd3;
    localparam logic [3:0] CS_DONE     = 4'd4;
    localparam logic [3:0] CS_ERR_BASE = 4'd8;
    localparam logic [3:0] CS_ERR_PRE  = 4'd9;
    localparam logic [3:0] CS_ERR_C    = 4'd10;
    localparam logic [3:0] CS_ERR_NOTIN = 4'd11;
    localparam logic [3:0] CS_ERR_IN   = 4'd12;
    localparam logic [3:0] CS_ERR_NOTIP = 4'd13;
    localparam logic [3:0] CS_ERR_ADDR = 4'd14;

    // media tracker steps (error steps equal their status codes)
    localparam logic [3:0] MS_SEEK      = 4'd0;
    localparam logic [3:0] MS_AUDIO     = 4'd1;
    localparam logic [3:0] MS_PORT      = 4'd2;
    localparam logic [3:0] MS_DONE      = 4'd3;
    localparam logic [3:0] MS_ERR_BASE  = 4'd8;
    localparam logic [3:0] MS_ERR_PRE   = 4'd8;
    localparam logic [3:0] MS_ERR_M     = 4'd9;
    localparam logic [3:0] MS_ERR_NOTAU = 4'd10;
    localparam logic [3:0] MS_ERR_PORT  = 4'd11;

    // port number parser
    localparam logic [1:0] NP_START  = 2'd0;
    localparam logic [1:0] NP_DIGITS = 2'd1;
    localparam logic [1:0] NP_DONE   = 2'd3;

    // report status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_START = 4'd1;
    localparam logic [3:0] ST_NO_C_ARG  = 4'd2;
    localparam logic [3:0] ST_NO_IN_ARG = 4'd4;
    localparam logic [3:0] ST_NO_ADDR   = 4'd6;
    localparam logic [3:0] ST_NO_C      = 4'd7;
    localparam logic [3:0] ST_NO_M_ARG  = 4'd9;
    localparam logic [3:0] ST_NO_PORT   = 4'd11;
    localparam logic [3:0] ST_NO_M      = 4'd12;

    localparam logic REPORT_ADDR  = 1'b0;
    localparam logic REPORT_FINAL = 1'b1;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_HT    = 8'h09;

    // keywords: c=, IN, IP4, m=, audio
    localparam int KW_COUNT = 5;
    localparam int KW_C     = 0;
    localparam int KW_IN    = 1;
    localparam int KW_IP4   = 2;
    localparam int KW_M     = 3;
    localparam int KW_AUDIO = 4;

    localparam logic [7:0] KW_TEXT [KW_COUNT][5] = '{
        '{8'h63, 8'h3D, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h4E, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h50, 8'h34, 8'h00, 8'h00},
        '{8'h6D, 8'h3D, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h75, 8'h64, 8'h69, 8'h6F}
    };
    localparam logic [6:0] KW_LEN [KW_COUNT] = '{7'd2, 7'd2, 7'd3, 7'd2, 7'd5};

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  tl;
        logic [4:0]  km;
        logic [3:0]  cs;
        logic [3:0]  ms;
        logic [15:0] pv;
        logic [1:0]  np;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode: MODE_START, tl: 7'd0, km: 5'h1F, cs: CS_SEEK, ms: MS_SEEK,
        pv: 16'd0, np: NP_START
    };

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]   count;
        report_item_t first;
        report_item_t second;
    } push_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              room;
    } queue_stat_t;

endpackage

### src/sdpcm_stream_if.sv
// Valid/ready channel interface with a typed payload.
// Depends on nothing; payload types come from sdpcm_pkg at instantiation.
`timescale 1ns / 1ps

interface sdpcm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/sdpcm_scanner.sv
// Byte scanner: tokenizer, keyword match, connection and media trackers.
// Depends on sdpcm_pkg.
`timescale 1ns / 1ps

module sdpcm_scanner #(
    parameter int MAX_TOKEN_LENGTH = sdpcm_pkg::MAX_TOKEN_LENGTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  sdpcm_pkg::text_item_t item,
    output sdpcm_pkg::push_t      push
);

    localparam logic [6:0] TL_MAX = 7'(MAX_TOKEN_LENGTH);

    sdpcm_pkg::scan_state_t state_reg;
    sdpcm_pkg::scan_state_t state_next;

    function automatic sdpcm_pkg::scan_state_t tok_begin(sdpcm_pkg::scan_state_t s);
        sdpcm_pkg::scan_state_t r;
        r = s;
        r.tl = 7'd0;
        r.km = 5'h1F;
        if (s.ms == sdpcm_pkg::MS_PORT)
        begin
            r.pv = 16'd0;
            r.np = sdpcm_pkg::NP_START;
        end
        return r;
    endfunction

    function automatic sdpcm_pkg::scan_state_t tok_add(sdpcm_pkg::scan_state_t s,
                                                       logic [7:0] b);
        sdpcm_pkg::scan_state_t r;
        logic [19:0] prod;
        logic        do_digit;
        r = s;
        for (int k = 0; k < sdpcm_pkg::KW_COUNT; k++)
        begin
            if (!(s.tl < sdpcm_pkg::KW_LEN[k]
                  && sdpcm_pkg::KW_TEXT[k][s.tl[2:0]] == b))
            begin
                r.km[k] = 1'b0;
            end
        end
        if (s.tl < TL_MAX)
        begin
            r.tl = s.tl + 7'd1;
        end
        do_digit = 1'b0;
        if (s.ms == sdpcm_pkg::MS_PORT && s.np != sdpcm_pkg::NP_DONE)
        begin
            if (s.np == sdpcm_pkg::NP_START)
            begin
                if (b inside {[sdpcm_pkg::CH_HT:sdpcm_pkg::CH_CR], sdpcm_pkg::CH_SP})
                begin
                    do_digit = 1'b0;
                end
                else if (b == sdpcm_pkg::CH_PLUS)
                begin
                    r.np = sdpcm_pkg::NP_DIGITS;
                end
                else if (b == sdpcm_pkg::CH_MINUS)
                begin
                    r.np = sdpcm_pkg::NP_DONE;
                    r.pv = 16'd0;
                end
                else
                begin
                    r.np = sdpcm_pkg::NP_DIGITS;
                    do_digit = 1'b1;
                end
            end
            else
            begin
                do_digit = 1'b1;
            end
        end
        if (do_digit)
        begin
            if (b inside {[sdpcm_pkg::CH_ZERO:sdpcm_pkg::CH_NINE]})
            begin
                // pv * 10 + digit, saturated at 16 bits
                prod = ({4'd0, s.pv} << 3) + ({4'd0, s.pv} << 1)
                     + {12'd0, b - sdpcm_pkg::CH_ZERO};
                r.pv = (prod > 20'h0FFFF) ? 16'hFFFF : prod[15:0];
            end
            else
            begin
                r.np = sdpcm_pkg::NP_DONE;
            end
        end
        return r;
    endfunction

    function automatic logic kw_hit(sdpcm_pkg::scan_state_t s, int k);
        return s.km[k] && (s.tl == sdpcm_pkg::KW_LEN[k]);
    endfunction

    function automatic sdpcm_pkg::scan_state_t tok_done(sdpcm_pkg::scan_state_t s);
        sdpcm_pkg::scan_state_t r;
        logic over;
        r = s;
        over = (s.tl >= TL_MAX);
        case (s.cs)
            sdpcm_pkg::CS_SEEK:
            begin
                if (over)
                    r.cs = sdpcm_pkg::CS_ERR_PRE;
                else if (kw_hit(s, sdpcm_pkg::KW_C))
                    r.cs = sdpcm_pkg::CS_IN;
            end
            sdpcm_pkg::CS_IN:
                r.cs = over ? sdpcm_pkg::CS_ERR_C
                     : (kw_hit(s, sdpcm_pkg::KW_IN) ? sdpcm_pkg::CS_IP4
                                                    : sdpcm_pkg::CS_ERR_NOTIN);
            sdpcm_pkg::CS_IP4:
                r.cs = over ? sdpcm_pkg::CS_ERR_IN
                     : (kw_hit(s, sdpcm_pkg::KW_IP4) ? sdpcm_pkg::CS_ADDR
                                                     : sdpcm_pkg::CS_ERR_NOTIP);
            sdpcm_pkg::CS_ADDR:
                r.cs = over ? sdpcm_pkg::CS_ERR_ADDR : sdpcm_pkg::CS_DONE;
            default:
                r.cs = s.cs;
        endcase
        case (s.ms)
            sdpcm_pkg::MS_SEEK:
            begin
                if (over)
                    r.ms = sdpcm_pkg::MS_ERR_PRE;
                else if (kw_hit(s, sdpcm_pkg::KW_M))
                    r.ms = sdpcm_pkg::MS_AUDIO;
            end
            sdpcm_pkg::MS_AUDIO:
                r.ms = over ? sdpcm_pkg::MS_ERR_M
                     : (kw_hit(s, sdpcm_pkg::KW_AUDIO) ? sdpcm_pkg::MS_PORT
                                                       : sdpcm_pkg::MS_ERR_NOTAU);
            sdpcm_pkg::MS_PORT:
                r.ms = over ? sdpcm_pkg::MS_ERR_PORT : sdpcm_pkg::MS_DONE;
            default:
                r.ms = s.ms;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] final_status(sdpcm_pkg::scan_state_t s);
        logic [3:0] st;
        if (s.mode == sdpcm_pkg::MODE_START)
            st = sdpcm_pkg::ST_BAD_START;
        else if (s.cs >= sdpcm_pkg::CS_ERR_BASE)
            st = s.cs - sdpcm_pkg::CS_ERR_BASE;
        else if (s.cs == sdpcm_pkg::CS_SEEK)
            st = sdpcm_pkg::ST_NO_C;
        else if (s.cs == sdpcm_pkg::CS_IN)
            st = sdpcm_pkg::ST_NO_C_ARG;
        else if (s.cs == sdpcm_pkg::CS_IP4)
            st = sdpcm_pkg::ST_NO_IN_ARG;
        else if (s.cs == sdpcm_pkg::CS_ADDR)
            st = sdpcm_pkg::ST_NO_ADDR;
        else if (s.ms >= sdpcm_pkg::MS_ERR_BASE)
            st = s.ms;
        else
        begin
            case (s.ms)
                sdpcm_pkg::MS_SEEK:  st = sdpcm_pkg::ST_NO_M;
                sdpcm_pkg::MS_AUDIO: st = sdpcm_pkg::ST_NO_M_ARG;
                sdpcm_pkg::MS_PORT:  st = sdpcm_pkg::ST_NO_PORT;
                default:             st = sdpcm_pkg::ST_OK;
            endcase
        end
        return st;
    endfunction

    sdpcm_pkg::scan_state_t  s;
    sdpcm_pkg::report_item_t addr_res;
    sdpcm_pkg::report_item_t final_res;
    logic                    echo;
    logic                    fin;
    logic [3:0]              st;
    logic [7:0]              b;

    always_comb
    begin
        s    = state_reg;
        b    = item.text_byte;
        echo = 1'b0;
        fin  = 1'b0;
        st   = sdpcm_pkg::ST_OK;
        if (b == sdpcm_pkg::CH_NUL)
        begin
            fin = 1'b1;
        end
        else if (b inside {sdpcm_pkg::CH_LF, sdpcm_pkg::CH_CR, sdpcm_pkg::CH_SP})
        begin
            if (s.mode == sdpcm_pkg::MODE_START)
            begin
                // separator first: empty first token that matches nothing
                s    = tok_begin(s);
                s.km = 5'd0;
                s    = tok_done(s);
            end
            else if (s.mode == sdpcm_pkg::MODE_TOKEN)
            begin
                s = tok_done(s);
            end
            s.mode = sdpcm_pkg::MODE_SKIP;
        end
        else
        begin
            if (s.mode != sdpcm_pkg::MODE_TOKEN)
            begin
                s = tok_begin(s);
            end
            echo = (s.cs == sdpcm_pkg::CS_ADDR);
            s    = tok_add(s, b);
            if (b == sdpcm_pkg::CH_EQ)
            begin
                s      = tok_done(s);
                s.mode = sdpcm_pkg::MODE_SKIP;
            end
            else
            begin
                s.mode = sdpcm_pkg::MODE_TOKEN;
            end
        end
        if (item.end_of_input)
        begin
            fin = 1'b1;
        end
        if (fin)
        begin
            if (s.mode == sdpcm_pkg::MODE_TOKEN)
            begin
                s = tok_done(s);
            end
            st         = final_status(s);
            state_next = sdpcm_pkg::SCAN_RESET;
        end
        else
        begin
            state_next = s;
        end

        addr_res.report_kind  = sdpcm_pkg::REPORT_ADDR;
        addr_res.address_char = b;
        addr_res.status       = sdpcm_pkg::ST_OK;
        addr_res.media_port   = 16'd0;
        addr_res.last_of_run  = 1'b0;

        final_res.report_kind  = sdpcm_pkg::REPORT_FINAL;
        final_res.address_char = 8'd0;
        final_res.status       = st;
        final_res.media_port   = (st == sdpcm_pkg::ST_OK) ? s.pv : 16'd0;
        final_res.last_of_run  = 1'b1;

        push.first  = echo ? addr_res : final_res;
        push.second = final_res;
        push.count  = accept ? ({1'b0, echo} + {1'b0, fin}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdpcm_pkg::SCAN_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/sdpcm_out_queue.sv
// Result queue: takes up to two results a cycle, hands out one a cycle while report_out.ready is high.
// Depends on sdpcm_pkg and sdpcm_stream_if.
`timescale 1ns / 1ps

module sdpcm_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdpcm_pkg::push_t       push,
    output sdpcm_pkg::queue_stat_t stat,
    sdpcm_stream_if.source         report_out
);

    localparam logic [sdpcm_pkg::QPTR_W-1:0] QLAST = sdpcm_pkg::QPTR_W'(sdpcm_pkg::QDEPTH - 1);

    sdpcm_pkg::report_item_t mem_reg [sdpcm_pkg::QDEPTH];
    logic [sdpcm_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sdpcm_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [sdpcm_pkg::QPTR_W-1:0] wr_ptr_inc;
    logic [sdpcm_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sdpcm_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [sdpcm_pkg::QLVL_W-1:0] level_reg;
    logic [sdpcm_pkg::QLVL_W-1:0] level_next;
    logic                         pop;

    function automatic logic [sdpcm_pkg::QPTR_W-1:0] ptr_inc(
        logic [sdpcm_pkg::QPTR_W-1:0] p);
        return (p == QLAST) ? '0 : p + 1'b1;
    endfunction

    assign pop                = report_out.valid && report_out.ready;
    assign report_out.valid   = (level_reg != '0);
    assign report_out.payload = mem_reg[rd_ptr_reg];

    assign stat.level = level_reg;
    assign stat.room  = (level_reg <= sdpcm_pkg::QLVL_W'(sdpcm_pkg::QDEPTH - 2));

    always_comb
    begin
        wr_ptr_inc = ptr_inc(wr_ptr_reg);
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + sdpcm_pkg::QLVL_W'(push.count)
                    - sdpcm_pkg::QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

### src/sdpcm_connection_media_extractor_unit.sv
// Top level of the SDP connection/media extractor.
// Depends on sdpcm_pkg, sdpcm_stream_if, sdpcm_scanner, sdpcm_out_queue.
`timescale 1ns / 1ps
//
//  channel     | dir | payload                                          | one request is
//  ------------+-----+--------------------------------------------------+-------------------
//  text_in     | in  | text_byte[8], end_of_input                       | one text byte
//  report_out  | out | report_kind, address_char[8], status[4],         | one address echo
//              |     | media_port[16], last_of_run                      | or final report
//
//  One byte per cycle while text_in.ready is high: the scanner state updates in the cycle
//  a byte is taken, and its 0..2 results land in a 4-entry queue in the same edge.
//  If the queue was empty, the first result is visible in the cycle after its byte; a byte
//  never waits on the output side unless fewer than two queue slots are free.
//  text_in.ready depends only on the queue fill, not on report_out.ready.
//  rst_n (async, active low) puts the scanner at start of text, empties the queue.

module sdp_connection_media_extractor_unit #(
    parameter int MAX_TOKEN_LENGTH = sdpcm_pkg::MAX_TOKEN_LENGTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sdpcm_stream_if.sink   text_in,
    sdpcm_stream_if.source report_out
);

    sdpcm_pkg::push_t       push;
    sdpcm_pkg::queue_stat_t q_stat;
    logic                   accept;

    // take a byte only when both of its possible results fit
    assign text_in.ready = q_stat.room;
    assign accept        = text_in.valid && text_in.ready;

    sdpcm_scanner #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_scanner (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (text_in.payload),
        .push   (push)
    );

    sdpcm_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .stat       (q_stat),
        .report_out (report_out)
    );

    // queue never overfills
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= sdpcm_pkg::QLVL_W'(sdpcm_pkg::QDEPTH))
        else $error("result queue overflow");

    // a byte flagged end_of_input has its report queued by the next cycle
    a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_in.payload.end_of_input |=> report_out.valid)
        else $error("end of text left no report");

    // address echoes carry no status, port or last flag
    a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
        report_out.valid && report_out.payload.report_kind == sdpcm_pkg::REPORT_ADDR
        |-> report_out.payload.status == sdpcm_pkg::ST_OK
            && report_out.payload.media_port == 16'd0
            && !report_out.payload.last_of_run)
        else $error("address echo carries report fields");

    // failed reports give no port and are marked last of run
    a_err_port: assert property (@(posedge clk) disable iff (!rst_n)
        report_out.valid && report_out.payload.report_kind == sdpcm_pkg::REPORT_FINAL
        && report_out.payload.status != sdpcm_pkg::ST_OK
        |-> report_out.payload.media_port == 16'd0 && report_out.payload.last_of_run)
        else $error("error report carries a port");

endmodule

### tb/sv/sdp_connection_media_extractor_unit_test.sv
// Self-checking testbench for sdp_connection_media_extractor_unit: directed script plus
// random SDP-like texts, checked against a cycle-free scanner predictor.
// Depends on sdpcm_pkg, sdpcm_stream_if and the RTL top level.
`timescale 1ns / 1ps

module sdp_connection_media_extractor_unit_test;

    import sdpcm_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int TOKEN_LIMIT   = MAX_TOKEN_LENGTH_DEF;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int LONG_HOLD     = 300;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES  = 20;    // quiet cycles after the last result
    localparam int WATCHDOG_NS   = 5_000_000;
    localparam int DIRECTED_N    = 24;

    // port-parser whitespace that is not a token separator
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // ------------------------------------------------------------------
    // Directed script. Rows with typed set carry their final report by hand
    // (empty text, extremes, no connection line); the rest go through the
    // predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]  text_byte;
        logic        end_of_input;
        logic        typed;
        logic [3:0]  status;
        logic [15:0] media_port;
    } script_row_t;

    localparam script_row_t SCRIPT [DIRECTED_N] = '{
        // zero byte straight after reset: empty text
        '{8'h00, 1'b0, 1'b1, ST_BAD_START, 16'd0},
        // zero byte that is also the last byte: a single report
        '{8'h00, 1'b1, 1'b1, ST_BAD_START, 16'd0},
        // top byte value as a lone token, closed by end of input
        '{8'hFF, 1'b1, 1'b1, ST_NO_C,      16'd0},
        // separator as the first byte: empty first token
        '{CH_SP, 1'b1, 1'b1, ST_NO_C,      16'd0},
        // "m=audio 7 c=IN IP4 9": the address byte also ends the text,
        // so the echo comes first and the report right behind it
        '{"m",   1'b0, 1'b0, ST_OK, 16'd0},
        '{CH_EQ, 1'b0, 1'b0, ST_OK, 16'd0},
        '{"a",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"u",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"d",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"i",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"o",   1'b0, 1'b0, ST_OK, 16'd0},
        '{CH_SP, 1'b0, 1'b0, ST_OK, 16'd0},
        '{"7",   1'b0, 1'b0, ST_OK, 16'd0},
        '{CH_LF, 1'b0, 1'b0, ST_OK, 16'd0},
        '{"c",   1'b0, 1'b0, ST_OK, 16'd0},
        '{CH_EQ, 1'b0, 1'b0, ST_OK, 16'd0},
        '{"I",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"N",   1'b0, 1'b0, ST_OK, 16'd0},
        '{CH_SP, 1'b0, 1'b0, ST_OK, 16'd0},
        '{"I",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"P",   1'b0, 1'b0, ST_OK, 16'd0},
        '{"4",   1'b0, 1'b0, ST_OK, 16'd0},
        '{CH_CR, 1'b0, 1'b0, ST_OK, 16'd0},
        '{"9",   1'b1, 1'b0, ST_OK, 16'd0}
    };

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    sdpcm_stream_if #(.payload_t(text_item_t))   text_if ();
    sdpcm_stream_if #(.payload_t(report_item_t)) report_if ();

    sdp_connection_media_extractor_unit #(
        .MAX_TOKEN_LENGTH (TOKEN_LIMIT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_if),
        .report_out (report_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scanner predictor state: a private copy of what the block tracks
    // ------------------------------------------------------------------
    logic [1:0]  text_mode;
    logic [6:0]  tok_len;
    logic [4:0]  kw_live;       // one bit per keyword still matching
    logic [3:0]  conn_stage;
    logic [3:0]  media_stage;
    logic [15:0] port_acc;
    logic [1:0]  digit_phase;

    // results caused by the byte just scanned (0..2)
    report_item_t scan_out [2];
    int           scan_n;

    // expected report requests, oldest first
    report_item_t pending_reports [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int items_sent     = 0;
    int fail_count     = 0;

    text_item_t text_buf [$];

    function automatic void text_restart();
        text_mode   = MODE_START;
        tok_len     = '0;
        kw_live     = '1;
        conn_stage  = CS_SEEK;
        media_stage = MS_SEEK;
        port_acc    = '0;
        digit_phase = NP_START;
    endfunction

    function automatic bit keyword_complete(int k);
        return kw_live[k] && (tok_len == KW_LEN[k]);
    endfunction

    function automatic void token_open();
        tok_len = '0;
        kw_live = '1;
        // a fresh port token restarts the number parser
        if (media_stage == MS_PORT)
        begin
            port_acc    = '0;
            digit_phase = NP_START;
        end
    endfunction

    // atoi-style port parse, saturating; '-' pins the value to zero
    function automatic void port_feed(logic [7:0] b);
        int v;
        if (digit_phase == NP_DONE)
            return;
        if (digit_phase == NP_START)
        begin
            if (b == CH_SP || (b >= CH_HT && b <= CH_CR))
                return;
            if (b == CH_PLUS)
            begin
                digit_phase = NP_DIGITS;
                return;
            end
            if (b == CH_MINUS)
            begin
                digit_phase = NP_DONE;
                port_acc    = '0;
                return;
            end
            digit_phase = NP_DIGITS;
        end
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            v = int'(port_acc) * 10 + (int'(b) - int'(CH_ZERO));
            port_acc = (v > 65535) ? 16'hFFFF : v[15:0];
        end
        else
            digit_phase = NP_DONE;
    endfunction

    function automatic void token_grow(logic [7:0] b);
        int k;
        for (k = 0; k < KW_COUNT; k++)
        begin
            if (tok_len >= KW_LEN[k] || KW_TEXT[k][tok_len] != b)
                kw_live[k] = 1'b0;
        end
        if (tok_len < TOKEN_LIMIT)
            tok_len++;
        if (media_stage == MS_PORT)
            port_feed(b);
    endfunction

    // both trackers consume the finished token
    function automatic void token_close();
        bit over;
        over = (tok_len >= TOKEN_LIMIT);
        case (conn_stage)
            CS_SEEK:
            begin
                if (over)
                    conn_stage = CS_ERR_PRE;
                else if (keyword_complete(KW_C))
                    conn_stage = CS_IN;
            end
            CS_IN:
                conn_stage = over ? CS_ERR_C : (keyword_complete(KW_IN) ? CS_IP4 : CS_ERR_NOTIN);
            CS_IP4:
                conn_stage = over ? CS_ERR_IN : (keyword_complete(KW_IP4) ? CS_ADDR : CS_ERR_NOTIP);
            CS_ADDR:
                conn_stage = over ? CS_ERR_ADDR : CS_DONE;
            default:
                ;
        endcase
        case (media_stage)
            MS_SEEK:
            begin
                if (over)
                    media_stage = MS_ERR_PRE;
                else if (keyword_complete(KW_M))
                    media_stage = MS_AUDIO;
            end
            MS_AUDIO:
                media_stage = over ? MS_ERR_M : (keyword_complete(KW_AUDIO) ? MS_PORT : MS_ERR_NOTAU);
            MS_PORT:
                media_stage = over ? MS_ERR_PORT : MS_DONE;
            default:
                ;
        endcase
    endfunction

    // connection errors outrank media errors
    function automatic logic [3:0] report_code();
        logic [3:0] code;
        if (text_mode == MODE_START)
            code = ST_BAD_START;
        else if (conn_stage >= CS_ERR_BASE)
            code = conn_stage - CS_ERR_BASE;
        else if (conn_stage == CS_SEEK)
            code = ST_NO_C;
        else if (conn_stage == CS_IN)
            code = ST_NO_C_ARG;
        else if (conn_stage == CS_IP4)
            code = ST_NO_IN_ARG;
        else if (conn_stage == CS_ADDR)
            code = ST_NO_ADDR;
        else if (media_stage >= MS_ERR_BASE)
            code = media_stage;
        else if (media_stage == MS_SEEK)
            code = ST_NO_M;
        else if (media_stage == MS_AUDIO)
            code = ST_NO_M_ARG;
        else if (media_stage == MS_PORT)
            code = ST_NO_PORT;
        else
            code = ST_OK;
        return code;
    endfunction

    function automatic void text_close();
        report_item_t r;
        logic [3:0]   code;
        if (text_mode == MODE_TOKEN)
            token_close();
        code = report_code();
        r = '{REPORT_FINAL, CH_NUL, code, (code == ST_OK) ? port_acc : 16'd0, 1'b1};
        scan_out[scan_n] = r;
        scan_n++;
        text_restart();
    endfunction

    // one accepted text byte -> scan_out[0 .. scan_n-1]
    function automatic void scan_byte(logic [7:0] b, logic eoi);
        bit           sep;
        report_item_t r;
        scan_n = 0;
        if (b == CH_NUL)
        begin
            text_close();
            return;
        end
        sep = (b == CH_LF || b == CH_CR || b == CH_SP);
        if (sep)
        begin
            if (text_mode == MODE_START)
            begin
                // leading separator: an empty token that matches nothing
                token_open();
                kw_live = '0;
                token_close();
            end
            else if (text_mode == MODE_TOKEN)
                token_close();
            text_mode = MODE_SKIP;
        end
        else
        begin
            if (text_mode != MODE_TOKEN)
                token_open();
            // address bytes are echoed as they come, '=' and overlong ones too
            if (conn_stage == CS_ADDR)
            begin
                r = '{REPORT_ADDR, b, ST_OK, 16'd0, 1'b0};
                scan_out[scan_n] = r;
                scan_n++;
            end
            token_grow(b);
            if (b == CH_EQ)
            begin
                token_close();
                text_mode = MODE_SKIP;
            end
            else
                text_mode = MODE_TOKEN;
        end
        if (eoi)
            text_close();
    endfunction

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] sep_char();
        logic [7:0] c;
        case ($urandom_range(2))
            0:       c = CH_LF;
            1:       c = CH_CR;
            default: c = CH_SP;
        endcase
        return c;
    endfunction

    function automatic void push_char(logic [7:0] b);
        text_item_t it;
        it.text_byte    = b;
        it.end_of_input = 1'b0;
        text_buf.push_back(it);
    endfunction

    function automatic void push_word(string s);
        int k;
        for (k = 0; k < s.len(); k++)
            push_char(s[k]);
    endfunction

    function automatic void push_seps();
        int n;
        int k;
        n = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
        for (k = 0; k < n; k++)
            push_char(sep_char());
    endfunction

    // keyword, now and then damaged: wrong letter, cut short, or one too long
    function automatic void push_keyword(string s);
        string m;
        int    pos;
        m = s;
        if ($urandom_range(99) < 8)
        begin
            pos = $urandom_range(0, m.len() - 1);
            case ($urandom_range(2))
                0:       m.putc(pos, 8'($urandom_range(33, 126)));
                1:       m = m.substr(0, pos - 1);
                default: m = {m, "4"};
            endcase
        end
        push_word(m);
    endfunction

    // free-form token; a few run right around the length limit
    function automatic void push_junk(bit allow_long);
        int         n;
        int         k;
        logic [7:0] c;
        if (allow_long && $urandom_range(99) < 4)
            n = $urandom_range(TOKEN_LIMIT - 1, TOKEN_LIMIT + 6);
        else
            n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
        begin
            do
            begin
                if ($urandom_range(3) == 0)
                    c = 8'($urandom_range(1, 255));
                else
                    c = 8'($urandom_range(33, 126));
            end
            while (c == CH_LF || c == CH_CR || c == CH_SP || (n > 12 && c == CH_EQ));
            push_char(c);
        end
    endfunction

    function automatic void push_conn_line();
        if ($urandom_range(99) < 10)
            return;
        push_keyword("c=");
        if ($urandom_range(1) == 1)
            push_seps();
        push_keyword("IN");
        push_seps();
        push_keyword("IP4");
        push_seps();
        if ($urandom_range(99) >= 5)
            push_junk(1'b1);
    endfunction

    function automatic void push_media_line();
        logic [7:0] lead;
        if ($urandom_range(99) < 10)
            return;
        push_keyword("m=");
        if ($urandom_range(1) == 1)
            push_seps();
        push_keyword("audio");
        push_seps();
        case ($urandom_range(10))
            0, 1, 2: push_word($sformatf("%0d", $urandom_range(0, 65535)));
            3:       push_word($sformatf("%0d", $urandom_range(0, 99)));
            4:       push_word($sformatf("%0d%0d", $urandom_range(6, 99),
                                         $urandom_range(0, 999999)));
            5:       push_word({"+", $sformatf("%0d", $urandom_range(0, 70000))});
            6:       push_word({"-", $sformatf("%0d", $urandom_range(0, 70000))});
            7:
            begin
                case ($urandom_range(2))
                    0:       lead = CH_HT;
                    1:       lead = CH_VT;
                    default: lead = CH_FF;
                endcase
                push_char(lead);
                push_word($sformatf("%0d", $urandom_range(0, 65535)));
            end
            8:       push_word({$sformatf("%0d", $urandom_range(0, 9999)), "kHz"});
            9:       push_word(($urandom_range(1) == 1) ? "65535" : "65536");
            default: push_junk(1'b1);
        endcase
    endfunction

    // one text: mostly well-formed SDP with random content, some raw noise
    function automatic void build_text();
        int         n;
        int         k;
        int         ending;
        logic [7:0] c;
        text_buf.delete();
        if ($urandom_range(99) < 20)
        begin
            n = $urandom_range(1, 40);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(7) == 0)
                    c = sep_char();
                else
                    c = 8'($urandom_range(0, 255));
                push_char(c);
            end
        end
        else
        begin
            if ($urandom_range(9) == 0)
                push_char(sep_char());
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++)
            begin
                push_junk(1'b1);
                push_seps();
            end
            if ($urandom_range(1) == 1)
            begin
                push_conn_line();
                push_seps();
                push_media_line();
            end
            else
            begin
                push_media_line();
                push_seps();
                push_conn_line();
            end
            if ($urandom_range(3) == 0)
            begin
                push_seps();
                push_junk(1'b0);
            end
        end
        // end of text: zero byte, end flag, or both
        ending = $urandom_range(3);
        if (text_buf.size() == 0 || ending == 1)
            push_char(CH_NUL);
        else if (ending == 2)
        begin
            push_char(CH_NUL);
            text_buf[text_buf.size() - 1].end_of_input = 1'b1;
        end
        else
        begin
            if (ending == 3)
                push_seps();
            text_buf[text_buf.size() - 1].end_of_input = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Text request driver. valid stays high across back-to-back requests;
    // a request is taken at the edge where ready was high, and its expected
    // reports are queued at that same edge.
    // ------------------------------------------------------------------
    task automatic offer_byte(input text_item_t item, input bit typed,
                              input report_item_t typed_rep);
        int k;
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(posedge clk);
        end
        text_if.valid   <= 1'b1;
        text_if.payload <= item;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        scan_byte(item.text_byte, item.end_of_input);
        if (typed)
            pending_reports.push_back(typed_rep);
        else
        begin
            for (k = 0; k < scan_n; k++)
                pending_reports.push_back(scan_out[k]);
        end
        items_sent++;
    endtask

    // sender goes quiet until every expected report is back
    task automatic hold_until_drained();
        text_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Report receiver: random stalls, plus one long hold-off on request
    // so the result queue fills and text_in backs up.
    // ------------------------------------------------------------------
    initial
    begin
        report_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                report_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            report_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Report checker: every accepted request against the oldest expectation
    // ------------------------------------------------------------------
    report_item_t want_rep;
    report_item_t got_rep;

    always @(posedge clk)
    begin
        if (rst_n && report_if.valid && report_if.ready)
        begin
            got_rep = report_if.payload;
            if (pending_reports.size() == 0)
            begin
                $error("report request with nothing expected: kind %0d char %0h status %0d",
                       got_rep.report_kind, got_rep.address_char, got_rep.status);
                fail_count++;
            end
            else
            begin
                want_rep = pending_reports.pop_front();
                if (got_rep.report_kind !== want_rep.report_kind)
                begin
                    $error("report_kind: expected %0d, actual %0d",
                           want_rep.report_kind, got_rep.report_kind);
                    fail_count++;
                end
                if (got_rep.address_char !== want_rep.address_char)
                begin
                    $error("address_char: expected %0h, actual %0h",
                           want_rep.address_char, got_rep.address_char);
                    fail_count++;
                end
                if (got_rep.status !== want_rep.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           want_rep.status, got_rep.status);
                    fail_count++;
                end
                if (got_rep.media_port !== want_rep.media_port)
                begin
                    $error("media_port: expected %0d, actual %0d",
                           want_rep.media_port, got_rep.media_port);
                    fail_count++;
                end
                if (got_rep.last_of_run !== want_rep.last_of_run)
                begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want_rep.last_of_run, got_rep.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        text_item_t   item;
        report_item_t rep;
        report_item_t no_rep;
        int           i;
        int           k;
        int           phase;
        int           next_phase;

        rst_n           <= 1'b0;
        text_if.valid   <= 1'b0;
        text_if.payload <= '0;
        no_rep = '0;
        text_restart();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script, no idling
        for (i = 0; i < DIRECTED_N; i++)
        begin
            item.text_byte    = SCRIPT[i].text_byte;
            item.end_of_input = SCRIPT[i].end_of_input;
            rep = '{REPORT_FINAL, CH_NUL, SCRIPT[i].status, SCRIPT[i].media_port, 1'b1};
            offer_byte(item, SCRIPT[i].typed, rep);
        end

        // random texts in four idling phases; each phase starts drained
        phase = -1;
        while (items_sent < DIRECTED_N + RANDOM_ITEMS)
        begin
            next_phase = (items_sent - DIRECTED_N) * 4 / RANDOM_ITEMS;
            if (next_phase > 3)
                next_phase = 3;
            if (next_phase != phase)
            begin
                hold_until_drained();
                phase = next_phase;
                case (phase)
                    0:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                        // sender keeps streaming into a blocked receiver
                        hold_request   = 1'b1;
                    end
                    1:
                    begin
                        send_idle_pct  = 73;
                        recv_stall_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 73;
                    end
                    default:
                    begin
                        send_idle_pct  = 24;
                        recv_stall_pct = 24;
                    end
                endcase
            end
            build_text();
            for (k = 0; k < text_buf.size(); k++)
                offer_byte(text_buf[k], 1'b0, no_rep);
        end

        // wind down: receiver always ready, wait out stray results
        text_if.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
